// ===== src/vps_pkg.sv =====
`default_nettype none
package vps_pkg;

    localparam int STACK_DEPTH = 8;
    // depth counter holds 0..STACK_DEPTH, index addresses 0..STACK_DEPTH-1
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [2:0] CMD_RESET      = 3'd0;
    localparam logic [2:0] CMD_INVALIDATE = 3'd1;
    localparam logic [2:0] CMD_ROOT       = 3'd2;
    localparam logic [2:0] CMD_PUSH       = 3'd3;
    localparam logic [2:0] CMD_REPLACE    = 3'd4;
    localparam logic [2:0] CMD_PRESENT    = 3'd5;
    localparam logic [2:0] CMD_BACK       = 3'd6;
    localparam logic [2:0] CMD_DISMISS    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] route;
        logic [63:0] expected_generation;
        logic [31:0] expected_route;
        logic        expected_modal;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] cur_generation;
        logic [31:0] cur_route;
        logic        cur_modal;
        logic [31:0] top_page;
    } t_out_item;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_BUMP,
        ACT_PUSH,
        ACT_REPLACE,
        ACT_PRESENT,
        ACT_CLEAR_OVL,
        ACT_POP,
        ACT_EXHAUST
    } t_act;

    typedef struct packed {
        logic               exhausted;
        logic [DEPTH_W-1:0] depth;
        logic [63:0]        generation;
        logic [31:0]        overlay;
        logic [31:0]        top;
    } t_view;

    typedef struct packed {
        logic [2:0] status;
        t_act       act;
    } t_decision;

endpackage
`default_nettype wire

// ===== src/vps_page_ram.sv =====
`default_nettype none
module vps_page_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [vps_pkg::IDX_W-1:0]  i_waddr,
    input  wire logic [31:0]                i_wdata,
    input  wire logic [vps_pkg::IDX_W-1:0]  i_raddr,
    output logic [31:0]                     o_rdata
);

    logic [31:0] r_mem [vps_pkg::STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/vps_cmd_check.sv =====
`default_nettype none
module vps_cmd_check (
    input  wire vps_pkg::t_in_item  i_item,
    input  wire vps_pkg::t_view     i_view,
    output vps_pkg::t_decision      o_dec
);

    logic        w_active;
    logic        w_shown;
    logic        w_gen_max;
    logic [31:0] w_view_route;
    logic        w_match;
    logic        w_needs_route;
    logic        w_busy_cmd;

    always_comb begin
        w_active  = !i_view.exhausted && (i_view.depth != '0) && (i_view.generation != '0);
        w_shown   = (i_view.overlay != '0);
        w_gen_max = (i_view.generation == '1);
        w_view_route = w_shown ? i_view.overlay : (w_active ? i_view.top : 32'd0);
        w_match = w_active && (i_item.expected_generation != '0)
                  && (i_item.expected_route != '0)
                  && (i_item.expected_generation == i_view.generation)
                  && (i_item.expected_route == w_view_route)
                  && (i_item.expected_modal == w_shown);
        w_needs_route = (i_item.cmd == vps_pkg::CMD_ROOT) || (i_item.cmd == vps_pkg::CMD_PUSH)
                        || (i_item.cmd == vps_pkg::CMD_REPLACE)
                        || (i_item.cmd == vps_pkg::CMD_PRESENT);
        w_busy_cmd = (i_item.cmd == vps_pkg::CMD_PUSH) || (i_item.cmd == vps_pkg::CMD_REPLACE)
                     || (i_item.cmd == vps_pkg::CMD_PRESENT);

        o_dec.status = vps_pkg::ST_OK;
        o_dec.act    = vps_pkg::ACT_NONE;

        priority if (i_view.exhausted) begin
            o_dec.status = vps_pkg::ST_EXHAUSTED;
        end else if (i_item.cmd == vps_pkg::CMD_RESET) begin
            priority if (i_item.route == '0) begin
                o_dec.status = vps_pkg::ST_INVALID;
            end else if (w_gen_max) begin
                o_dec.status = vps_pkg::ST_EXHAUSTED;
                o_dec.act    = vps_pkg::ACT_EXHAUST;
            end else begin
                o_dec.act    = vps_pkg::ACT_LOAD;
            end
        end else if (i_item.cmd == vps_pkg::CMD_INVALIDATE) begin
            priority if (!w_active) begin
                o_dec.status = vps_pkg::ST_INVALID;
            end else if (w_gen_max) begin
                o_dec.status = vps_pkg::ST_EXHAUSTED;
                o_dec.act    = vps_pkg::ACT_EXHAUST;
            end else begin
                o_dec.act    = vps_pkg::ACT_BUMP;
            end
        end else if (w_needs_route ? (i_item.route == '0) : (i_item.route != '0)) begin
            o_dec.status = vps_pkg::ST_INVALID;
        end else if (!w_match) begin
            o_dec.status = vps_pkg::ST_STALE;
        end else if (w_shown && w_busy_cmd) begin
            o_dec.status = vps_pkg::ST_BUSY;
        end else if ((i_item.cmd == vps_pkg::CMD_PUSH)
                     && (i_view.depth >= vps_pkg::DEPTH_W'(vps_pkg::STACK_DEPTH))) begin
            o_dec.status = vps_pkg::ST_FULL;
        end else if ((i_item.cmd == vps_pkg::CMD_BACK) && !w_shown
                     && (i_view.depth <= vps_pkg::DEPTH_W'(1))) begin
            o_dec.status = vps_pkg::ST_EMPTY;
        end else if ((i_item.cmd == vps_pkg::CMD_DISMISS) && !w_shown) begin
            o_dec.status = vps_pkg::ST_EMPTY;
        end else if (w_gen_max) begin
            o_dec.status = vps_pkg::ST_EXHAUSTED;
            o_dec.act    = vps_pkg::ACT_EXHAUST;
        end else begin
            unique case (i_item.cmd)
                vps_pkg::CMD_ROOT:    o_dec.act = vps_pkg::ACT_LOAD;
                vps_pkg::CMD_PUSH:    o_dec.act = vps_pkg::ACT_PUSH;
                vps_pkg::CMD_REPLACE: o_dec.act = vps_pkg::ACT_REPLACE;
                vps_pkg::CMD_PRESENT: o_dec.act = vps_pkg::ACT_PRESENT;
                vps_pkg::CMD_BACK: begin
                    o_dec.act = w_shown ? vps_pkg::ACT_CLEAR_OVL : vps_pkg::ACT_POP;
                end
                default:              o_dec.act = vps_pkg::ACT_CLEAR_OVL;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/versioned_page_stack_top.sv =====
`default_nettype none
// Versioned page stack. A command is taken when start is high and busy is low,
// and its single result appears on o_result for one cycle with o_done high;
// the receiver cannot hold it off, so it must capture the beat when o_done is
// set. Each command passes through an execute state and a response state before
// its result beat; a back that pops a page also passes through a fetch state,
// as the new top page is read back from the page memory. A new command may be
// issued in the same cycle as the result beat. The pages live in a small
// synchronous memory and the current top page is cached in a register, so
// only a pop needs a memory read.
module versioned_page_stack_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire vps_pkg::t_in_item  i_item,
    output logic                    busy,
    output logic                    o_done,
    output vps_pkg::t_out_item      o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FETCH = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    vps_pkg::t_in_item          r_item;
    logic [vps_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic [63:0]                r_gen, n_gen;
    logic [31:0]                r_overlay, n_overlay;
    logic                       r_exh, n_exh;
    logic [31:0]                r_top, n_top;
    logic [2:0]                 r_status, n_status;
    logic                       r_done;
    vps_pkg::t_out_item         r_out, n_out;

    vps_pkg::t_view             w_view;
    vps_pkg::t_decision         w_dec;
    logic                       w_we;
    logic [vps_pkg::IDX_W-1:0]  w_waddr;
    logic [31:0]                w_wdata;
    logic [vps_pkg::IDX_W-1:0]  w_raddr;
    logic [31:0]                w_rdata;
    logic [vps_pkg::DEPTH_W-1:0] w_dm1;
    logic [vps_pkg::DEPTH_W-1:0] w_dm2;
    logic                       w_active;

    assign w_view = '{exhausted: r_exh, depth: r_depth, generation: r_gen,
                      overlay: r_overlay, top: r_top};

    vps_cmd_check u_check (
        .i_item (r_item),
        .i_view (w_view),
        .o_dec  (w_dec)
    );

    vps_page_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_dm1 = r_depth - vps_pkg::DEPTH_W'(1);
    assign w_dm2 = r_depth - vps_pkg::DEPTH_W'(2);
    assign w_active = !r_exh && (r_depth != '0) && (r_gen != '0);

    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_gen     = r_gen;
        n_overlay = r_overlay;
        n_exh     = r_exh;
        n_top     = r_top;
        n_status  = r_status;
        n_out     = r_out;
        w_we      = 1'b0;
        w_waddr   = w_dm1[vps_pkg::IDX_W-1:0];
        w_wdata   = r_item.route;
        // the read port points at the entry below the top for a pop
        w_raddr   = w_dm2[vps_pkg::IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = w_dec.status;
                n_state  = S_RESP;
                if ((w_dec.act != vps_pkg::ACT_NONE) && (w_dec.act != vps_pkg::ACT_EXHAUST)) begin
                    n_gen = r_gen + 64'd1;
                end
                unique case (w_dec.act)
                    vps_pkg::ACT_LOAD: begin
                        w_we      = 1'b1;
                        w_waddr   = '0;
                        n_depth   = vps_pkg::DEPTH_W'(1);
                        n_overlay = '0;
                        n_top     = r_item.route;
                    end
                    vps_pkg::ACT_PUSH: begin
                        w_we    = 1'b1;
                        w_waddr = r_depth[vps_pkg::IDX_W-1:0];
                        n_depth = r_depth + vps_pkg::DEPTH_W'(1);
                        n_top   = r_item.route;
                    end
                    vps_pkg::ACT_REPLACE: begin
                        w_we  = 1'b1;
                        n_top = r_item.route;
                    end
                    vps_pkg::ACT_PRESENT:   n_overlay = r_item.route;
                    vps_pkg::ACT_CLEAR_OVL: n_overlay = '0;
                    vps_pkg::ACT_POP: begin
                        // a pop never writes, so the read cannot collide
                        n_depth = w_dm1;
                        n_state = S_FETCH;
                    end
                    vps_pkg::ACT_EXHAUST:   n_exh = 1'b1;
                    default: ;
                endcase
            end
            S_FETCH: begin
                n_top   = w_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                n_out.status = r_status;
                if (w_active) begin
                    n_out.cur_generation = r_gen;
                    n_out.cur_route      = (r_overlay != '0) ? r_overlay : r_top;
                    n_out.cur_modal      = (r_overlay != '0);
                    n_out.top_page       = r_top;
                end else begin
                    n_out.cur_generation = '0;
                    n_out.cur_route      = '0;
                    n_out.cur_modal      = 1'b0;
                    n_out.top_page       = '0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_gen     <= '0;
            r_overlay <= '0;
            r_exh     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_gen     <= n_gen;
            r_overlay <= n_overlay;
            r_exh     <= n_exh;
            r_done    <= (r_state == S_RESP);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_item <= i_item;
        end
        r_top    <= n_top;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    a_done_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_RESP))
        else $error("result beat without a response cycle");

    a_exh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exh |=> r_exh)
        else $error("exhausted state left without reset");

    a_gen_only_in_exec: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && !$stable(r_gen)) |-> $past(r_state == S_EXEC))
        else $error("generation changed outside command execution");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= vps_pkg::DEPTH_W'(vps_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_fetch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_depth != '0))
        else $error("top page fetched from an empty stack");

endmodule
`default_nettype wire
